>>> design/sadb_pkg.sv
// Shared types, codes and size tables for the sprite attribute decoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sadb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_DATA_W = 10;

  localparam logic [1:0] SHAPE_INVALID = 2'd3;

  typedef enum logic [1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_BOUNDS = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [0:0] {
    REG_CANVAS_MARGIN = 1'b0,
    REG_CANVAS_LIMIT  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t              kind;
    logic               last;
    logic signed [9:0]  x_value;
    logic signed [8:0]  y_value;
    logic [9:0]         width_value;
    logic [8:0]         height_value;
    logic [9:0]         tile_number;
    logic [1:0]         draw_priority;
    logic [3:0]         palette_number;
    logic [1:0]         object_mode;
    logic [4:0]         matrix_index;
    logic [3:0]         flag_bits;
  } result_t;

  function automatic logic [6:0] size_width(input logic [1:0] shape, input logic [1:0] sz);
    logic [6:0] w;
    w = 7'd0;
    unique case ({shape, sz})
      4'b0000: w = 7'd8;
      4'b0001: w = 7'd16;
      4'b0010: w = 7'd32;
      4'b0011: w = 7'd64;
      4'b0100: w = 7'd16;
      4'b0101: w = 7'd32;
      4'b0110: w = 7'd32;
      4'b0111: w = 7'd64;
      4'b1000: w = 7'd8;
      4'b1001: w = 7'd8;
      4'b1010: w = 7'd16;
      4'b1011: w = 7'd32;
      default: w = 7'd0;
    endcase
    return w;
  endfunction

  function automatic logic [6:0] size_height(input logic [1:0] shape, input logic [1:0] sz);
    logic [6:0] h;
    h = 7'd0;
    unique case ({shape, sz})
      4'b0000: h = 7'd8;
      4'b0001: h = 7'd16;
      4'b0010: h = 7'd32;
      4'b0011: h = 7'd64;
      4'b0100: h = 7'd8;
      4'b0101: h = 7'd8;
      4'b0110: h = 7'd16;
      4'b0111: h = 7'd32;
      4'b1000: h = 7'd16;
      4'b1001: h = 7'd32;
      4'b1010: h = 7'd32;
      4'b1011: h = 7'd64;
      default: h = 7'd0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

>>> design/sprite_attribute_decode_bounds.sv
// The results of an entry are registered in the result queue at its input transfer.
// One entry is taken per cycle while the queue has room; an entry that closes a cell
// produces two results, so a steady run of such entries is held back by the result port.
// The input side stalls only when the four-entry result queue has fewer than two free slots.
// Reset (synchronous, active high) empties the queue, clears the running bounds and
// sets canvas_margin to 8 and canvas_limit to 512.
`default_nettype none

module sprite_attribute_decode_bounds (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // attr_word0 [15:0], attr_word1 [31:16], attr_word2 [47:32]
  input  wire logic [sadb_pkg::IN_DATA_W-1:0]    s_tdata,
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // x_value [9:0], y_value [18:10], width_value [28:19], height_value [37:29],
  // tile_number [47:38], draw_priority [49:48], palette_number [53:50],
  // object_mode [55:54], matrix_index [60:56], flag_bits [64:61], zeros above
  output logic [sadb_pkg::OUT_DATA_W-1:0]        m_tdata,
  // kind [1:0]
  output logic [1:0]                             m_tuser,
  output logic                                   m_tlast,
  input  wire logic                              cfg_write,
  input  wire logic                              cfg_index,
  input  wire logic [sadb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [5:0]         canvas_margin;
  logic [9:0]         canvas_limit;
  logic signed [10:0] lowest_x;
  logic signed [10:0] highest_x;
  logic signed [9:0]  lowest_y;
  logic signed [9:0]  highest_y;
  logic               seen_valid;

  logic signed [10:0] lowest_x_next;
  logic signed [10:0] highest_x_next;
  logic signed [9:0]  lowest_y_next;
  logic signed [9:0]  highest_y_next;
  logic               seen_valid_next;

  sadb_pkg::result_t  entry;
  sadb_pkg::result_t  first;
  sadb_pkg::result_t  bounds;
  sadb_pkg::result_t  out_item;
  logic               shape_ok;
  logic               in_fire;
  logic               room;

  logic signed [10:0] x_start;
  logic signed [10:0] x_end;
  logic signed [9:0]  y_start;
  logic signed [9:0]  y_end;
  logic signed [10:0] span_x;
  logic signed [9:0]  span_y;
  logic signed [11:0] total_x;
  logic signed [11:0] total_y;
  logic signed [11:0] margin2;
  logic signed [11:0] limit_ext;
  logic               fits;

  sadb_decode u_decode (
    .word0    (s_tdata[15:0]),
    .word1    (s_tdata[31:16]),
    .word2    (s_tdata[47:32]),
    .entry    (entry),
    .shape_ok (shape_ok)
  );

  assign s_tready = room;
  assign in_fire  = s_tvalid & room;

  assign x_start = {entry.x_value[9], entry.x_value};
  assign x_end   = x_start + $signed({1'b0, entry.width_value});
  assign y_start = {entry.y_value[8], entry.y_value};
  assign y_end   = y_start + $signed({1'b0, entry.height_value});

  assign lowest_x_next   = (shape_ok && (x_start < lowest_x)) ? x_start : lowest_x;
  assign highest_x_next  = (shape_ok && (x_end > highest_x)) ? x_end : highest_x;
  assign lowest_y_next   = (shape_ok && (y_start < lowest_y)) ? y_start : lowest_y;
  assign highest_y_next  = (shape_ok && (y_end > highest_y)) ? y_end : highest_y;
  assign seen_valid_next = seen_valid | shape_ok;

  assign span_x    = highest_x_next - lowest_x_next;
  assign span_y    = highest_y_next - lowest_y_next;
  assign margin2   = $signed({5'd0, canvas_margin, 1'b0});
  assign limit_ext = $signed({2'd0, canvas_limit});
  assign total_x   = $signed({span_x[10], span_x}) + margin2;
  assign total_y   = $signed({{2{span_y[9]}}, span_y}) + margin2;
  assign fits      = (total_x > 12'sd0) && (total_x <= limit_ext)
                  && (total_y > 12'sd0) && (total_y <= limit_ext);

  always_comb begin
    first      = entry;
    first.last = ~s_tlast;
    bounds      = '0;
    bounds.kind = sadb_pkg::KIND_BOUNDS;
    bounds.last = 1'b1;
    if (seen_valid_next) begin
      bounds.x_value      = lowest_x_next[9:0];
      bounds.y_value      = lowest_y_next[8:0];
      bounds.width_value  = span_x[9:0];
      bounds.height_value = span_y[8:0];
      bounds.flag_bits    = {3'd0, fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_x   <= 11'sd1023;
      highest_x  <= -11'sd1024;
      lowest_y   <= 10'sd511;
      highest_y  <= -10'sd512;
      seen_valid <= 1'b0;
    end else if (in_fire) begin
      if (s_tlast) begin
        lowest_x   <= 11'sd1023;
        highest_x  <= -11'sd1024;
        lowest_y   <= 10'sd511;
        highest_y  <= -10'sd512;
        seen_valid <= 1'b0;
      end else begin
        lowest_x   <= lowest_x_next;
        highest_x  <= highest_x_next;
        lowest_y   <= lowest_y_next;
        highest_y  <= highest_y_next;
        seen_valid <= seen_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_margin <= 6'd8;
      canvas_limit  <= 10'd512;
    end else if (cfg_write) begin
      unique case (sadb_pkg::cfg_reg_t'(cfg_index))
        sadb_pkg::REG_CANVAS_MARGIN: canvas_margin <= cfg_data[5:0];
        sadb_pkg::REG_CANVAS_LIMIT:  canvas_limit  <= cfg_data;
      endcase
    end
  end

  sadb_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire),
    .push_two  (s_tlast),
    .first     (first),
    .second    (bounds),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tuser = out_item.kind;
  assign m_tlast = out_item.last;
  assign m_tdata = {7'd0,
                    out_item.flag_bits,
                    out_item.matrix_index,
                    out_item.object_mode,
                    out_item.palette_number,
                    out_item.draw_priority,
                    out_item.tile_number,
                    out_item.height_value,
                    out_item.width_value,
                    out_item.y_value,
                    out_item.x_value};

endmodule

`default_nettype wire

>>> design/sadb_decode.sv
// Combinational decode of one sprite entry from its three attribute words.
// Depends on sadb_pkg for the result type and the shape/size tables.
`default_nettype none

module sadb_decode (
  input  wire logic [15:0]      word0,
  input  wire logic [15:0]      word1,
  input  wire logic [15:0]      word2,
  output sadb_pkg::result_t     entry,
  output logic                  shape_ok
);

  logic [1:0]        shape;
  logic [1:0]        sz;
  logic              aff;
  logic              dbl;
  logic              flip_h;
  logic              flip_v;
  logic [6:0]        w7;
  logic [6:0]        h7;
  logic signed [9:0] x_raw;
  logic signed [8:0] y_raw;
  logic [9:0]        x_off;
  logic [8:0]        y_off;

  assign shape    = word0[15:14];
  assign sz       = word1[15:14];
  assign shape_ok = (shape != sadb_pkg::SHAPE_INVALID);
  assign aff      = word0[8];
  assign dbl      = aff & word0[9];
  assign flip_h   = ~aff & word1[12];
  assign flip_v   = ~aff & word1[13];
  assign w7       = sadb_pkg::size_width(shape, sz);
  assign h7       = sadb_pkg::size_height(shape, sz);
  assign x_raw    = $signed({word1[8], word1[8:0]});
  assign y_raw    = $signed({word0[7], word0[7:0]});
  assign x_off    = dbl ? {4'd0, w7[6:1]} : 10'd0;
  assign y_off    = dbl ? {3'd0, h7[6:1]} : 9'd0;

  always_comb begin
    entry = '0;
    if (shape_ok) begin
      entry.kind           = sadb_pkg::KIND_ENTRY;
      entry.x_value        = x_raw + $signed(x_off);
      entry.y_value        = y_raw + $signed(y_off);
      entry.width_value    = {3'd0, w7};
      entry.height_value   = {2'd0, h7};
      entry.tile_number    = word2[9:0];
      entry.draw_priority  = word2[11:10];
      entry.palette_number = word2[15:12];
      entry.object_mode    = word0[11:10];
      entry.matrix_index   = word1[13:9];
      entry.flag_bits      = {flip_v, flip_h, dbl, aff};
    end else begin
      entry.kind = sadb_pkg::KIND_ERROR;
    end
  end

endmodule

`default_nettype wire

>>> design/sadb_result_queue.sv
// Small result queue that takes one or two results per cycle and hands out one when out_ready is high.
// Depends on sadb_pkg for the result type and the queue depth.
`default_nettype none

module sadb_result_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              push_two,
  input  wire sadb_pkg::result_t first,
  input  wire sadb_pkg::result_t second,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sadb_pkg::result_t      out_item
);

  sadb_pkg::result_t                  mem [sadb_pkg::QUEUE_DEPTH];
  logic [sadb_pkg::QUEUE_PTR_W-1:0]   wr_ptr;
  logic [sadb_pkg::QUEUE_PTR_W-1:0]   rd_ptr;
  logic [sadb_pkg::QUEUE_PTR_W-1:0]   wr_ptr_next;
  logic [sadb_pkg::QUEUE_PTR_W-1:0]   wr_ptr_second;
  logic [sadb_pkg::QUEUE_CNT_W-1:0]   count;
  logic [sadb_pkg::QUEUE_CNT_W-1:0]   count_next;
  logic [sadb_pkg::QUEUE_CNT_W-1:0]   push_count;
  logic                               pop;

  assign out_valid     = (count != '0);
  assign out_item      = mem[rd_ptr];
  assign pop           = out_valid & out_ready;
  assign room          = (count <= sadb_pkg::QUEUE_CNT_W'(sadb_pkg::QUEUE_DEPTH - 2));
  assign push_count    = push ? (push_two ? sadb_pkg::QUEUE_CNT_W'(2)
                                          : sadb_pkg::QUEUE_CNT_W'(1))
                              : '0;
  assign wr_ptr_second = wr_ptr + sadb_pkg::QUEUE_PTR_W'(1);
  assign wr_ptr_next   = wr_ptr + push_count[sadb_pkg::QUEUE_PTR_W-1:0];
  assign count_next    = count + push_count - {{(sadb_pkg::QUEUE_CNT_W-1){1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + sadb_pkg::QUEUE_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= first;
      if (push_two) begin
        mem[wr_ptr_second] <= second;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sadb_checker.sv
// Port-level checks for the sprite attribute decoder, bound to its top level.
// Depends on sadb_pkg for the result kind codes and the output data width.
`default_nettype none

module sadb_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [sadb_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic [1:0]                        m_tuser,
  input wire logic                              m_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_bounds_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sadb_pkg::KIND_BOUNDS) |-> m_tlast)
    else $error("bounds transfer without last");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == sadb_pkg::KIND_ERROR) |-> (m_tdata == '0))
    else $error("error transfer carries nonzero data");

endmodule

bind sprite_attribute_decode_bounds sadb_checker u_sadb_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
